// ===== sv/bmd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmd_pkg;

    localparam int BYTE_W    = 8;
    localparam int ID_W      = 2 * BYTE_W;
    localparam int KIND_W    = 3;
    localparam int NUM_KINDS = 1 << KIND_W;
    localparam int LEN_W     = 12;
    localparam int LEN_DIGITS = 3;
    localparam int ROT_BITS  = 2;

    // kind codes, in the order of msg_kind
    localparam logic [KIND_W-1:0] KIND_RE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UO = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PG = 3'd4;
    localparam logic [KIND_W-1:0] KIND_VG = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DP = 3'd6;
    localparam logic [KIND_W-1:0] KIND_GO = 3'd7;

    // ASCII identifiers, first byte high, indexed by kind
    localparam logic [ID_W-1:0] ID_CODES [NUM_KINDS] = '{
        16'h5245, // RE
        16'h4754, // GT
        16'h554F, // UO
        16'h5244, // RD
        16'h5047, // PG
        16'h5647, // VG
        16'h4450, // DP
        16'h474F  // GO
    };

    typedef struct packed {
        logic [KIND_W-1:0] msg_kind;
        logic [LEN_W-1:0]  body_length;
        logic              check_ok;
        logic [BYTE_W-1:0] computed_sum;
        logic [BYTE_W-1:0] received_sum;
    } bmd_result_t;

endpackage

`default_nettype wire

// ===== sv/bmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bmd_rx_if;
    logic                       valid;
    logic                       ready;
    logic [bmd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bmd_msg_if;
    logic                       valid;
    logic                       ready;
    logic [bmd_pkg::KIND_W-1:0] msg_kind;
    logic [bmd_pkg::LEN_W-1:0]  body_length;
    logic                       check_ok;
    logic [bmd_pkg::BYTE_W-1:0] computed_sum;
    logic [bmd_pkg::BYTE_W-1:0] received_sum;

    modport source (output valid, output msg_kind, output body_length, output check_ok,
                    output computed_sum, output received_sum, input ready);
    modport sink   (input valid, input msg_kind, input body_length, input check_ok,
                    input computed_sum, input received_sum, output ready);
endinterface

`default_nettype wire

// ===== sv/binary_message_deframer.sv =====
// Binary message deframer. Bytes come in on rx, one request per byte, and a
// result leaves on msg once per finished message. The block hunts for one of
// the two-byte identifiers RE, GT, UO, RD, PG, VG, DP or GO (first byte sent
// first), sliding the window one byte on a miss. It then reads three ASCII hex
// length characters (a non-hex character ends the number; later characters
// still count toward the checksum) and that many body bytes, the last of which
// is the received checksum. The computed checksum runs over the identifier,
// the length characters and all body bytes but the last: rotate left by 2, XOR
// the byte, with one final rotate at the end. check_ok is set when the two
// sums agree, and always for RE. A zero length ends the message right after
// the length characters with received_sum 0 and check_ok clear (set for RE).
// After each message two fresh bytes are needed before matching resumes.
// Rate: one byte per clock, sustained while msg is ready. Each byte is handled by one pass of
// the parser's next-state logic; the result sits in an output register and
// appears on msg the cycle after the byte that ends the message. rx takes a
// byte whenever that register is empty or is being drained in the same
// cycle, and stalls while it holds a result and msg is not ready.
`timescale 1ns / 1ps
`default_nettype none

module binary_message_deframer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bmd_rx_if.sink     rx,
    bmd_msg_if.source  msg
);
    import bmd_pkg::*;

    logic        advance;
    logic        result_valid;
    bmd_result_t result;

    logic        out_valid_reg, out_valid_next;
    bmd_result_t out_data_reg;

    // output register free, or being drained this cycle
    assign rx.ready = !out_valid_reg || msg.ready;
    assign advance  = rx.valid && rx.ready;

    bmd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .rx_byte      (rx.rx_byte),
        .result_valid (result_valid),
        .result       (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (result_valid) begin
            out_valid_next = 1'b1;
        end else if (msg.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload only; no reset needed
    always_ff @(posedge clk) begin
        if (result_valid) begin
            out_data_reg <= result;
        end
    end

    assign msg.valid        = out_valid_reg;
    assign msg.msg_kind     = out_data_reg.msg_kind;
    assign msg.body_length  = out_data_reg.body_length;
    assign msg.check_ok     = out_data_reg.check_ok;
    assign msg.computed_sum = out_data_reg.computed_sum;
    assign msg.received_sum = out_data_reg.received_sum;

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> msg.valid)
        else $error("finished message not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !out_valid_reg || msg.ready)
        else $error("result overwrote a pending one");

endmodule

`default_nettype wire

// ===== sv/bmd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmd_parser (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [bmd_pkg::BYTE_W-1:0] rx_byte,
    output logic                            result_valid,
    output bmd_pkg::bmd_result_t            result
);
    import bmd_pkg::*;

    typedef enum logic [1:0] {
        HUNT,
        LENGTH,
        BODY
    } phase_t;

    function automatic logic [BYTE_W-1:0] rotl8(input logic [BYTE_W-1:0] v);
        return (v << ROT_BITS) | (v >> (BYTE_W - ROT_BITS));
    endfunction

    phase_t              phase_reg,  phase_next;
    logic [ID_W-1:0]     window_reg, window_next;
    logic [1:0]          fill_reg,   fill_next;
    logic [LEN_W-1:0]    len_reg,    len_next;
    logic [1:0]          digits_reg, digits_next;
    logic                stop_reg,   stop_next;
    logic [LEN_W-1:0]    left_reg,   left_next;
    logic [BYTE_W-1:0]   sum_reg,    sum_next;
    logic [KIND_W-1:0]   kind_reg,   kind_next;

    logic [ID_W-1:0]     window_shift;
    logic                match_hit;
    logic [KIND_W-1:0]   match_kind;
    logic                hex_ok;
    logic [3:0]          hex_digit;
    logic [BYTE_W-1:0]   sum_upd;
    logic [LEN_W-1:0]    len_upd;
    logic                emit;

    // identifier compare against all kinds at once
    assign window_shift = {window_reg[BYTE_W-1:0], rx_byte};
    always_comb begin
        match_hit  = 1'b0;
        match_kind = KIND_RE;
        for (int k = NUM_KINDS - 1; k >= 0; k--) begin
            if (ID_CODES[k] == window_shift) begin
                match_hit  = 1'b1;
                match_kind = KIND_W'(k);
            end
        end
    end

    always_comb begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
            hex_digit = 4'(rx_byte - 8'h30);
        end else if (rx_byte >= 8'h61 && rx_byte <= 8'h66) begin
            hex_digit = 4'(rx_byte - 8'h57);
        end else if (rx_byte >= 8'h41 && rx_byte <= 8'h46) begin
            hex_digit = 4'(rx_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign sum_upd = rotl8(sum_reg) ^ rx_byte;
    assign len_upd = (!stop_reg && hex_ok) ? {len_reg[LEN_W-5:0], hex_digit} : len_reg;

    always_comb begin
        phase_next  = phase_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        digits_next = digits_reg;
        stop_next   = stop_reg;
        left_next   = left_reg;
        sum_next    = sum_reg;
        kind_next   = kind_reg;
        emit        = 1'b0;
        result      = '0;
        result.msg_kind = kind_reg;

        unique case (phase_reg)
            HUNT: begin
                window_next = window_shift;
                if (fill_reg < 2'd2) begin
                    fill_next = fill_reg + 2'd1;
                end
                if (fill_reg != 2'd0 && match_hit) begin
                    kind_next   = match_kind;
                    phase_next  = LENGTH;
                    len_next    = '0;
                    digits_next = '0;
                    stop_next   = 1'b0;
                    sum_next    = rotl8(window_reg[BYTE_W-1:0]) ^ rx_byte;
                end
            end
            LENGTH: begin
                sum_next    = sum_upd;
                len_next    = len_upd;
                stop_next   = stop_reg | ~hex_ok;
                digits_next = digits_reg + 2'd1;
                if (digits_reg == 2'(LEN_DIGITS - 1)) begin
                    if (len_upd == '0) begin
                        emit                = 1'b1;
                        result.body_length  = '0;
                        result.computed_sum = rotl8(sum_upd);
                        result.received_sum = '0;
                        result.check_ok     = (kind_reg == KIND_RE);
                    end else begin
                        left_next  = len_upd;
                        phase_next = BODY;
                    end
                end
            end
            BODY: begin
                if (left_reg > LEN_W'(1)) begin
                    sum_next  = sum_upd;
                    left_next = left_reg - LEN_W'(1);
                end else begin
                    emit                = 1'b1;
                    result.body_length  = len_reg;
                    result.computed_sum = rotl8(sum_reg);
                    result.received_sum = rx_byte;
                    result.check_ok     = (kind_reg == KIND_RE)
                                          || (rotl8(sum_reg) == rx_byte);
                end
            end
            default: begin
                phase_next = HUNT;
            end
        endcase

        // end of message: empty the window so two fresh bytes are taken
        if (emit) begin
            phase_next  = HUNT;
            window_next = '0;
            fill_next   = '0;
            len_next    = '0;
            digits_next = '0;
            stop_next   = 1'b0;
            left_next   = '0;
            sum_next    = '0;
        end
    end

    assign result_valid = advance & emit;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg  <= HUNT;
            window_reg <= '0;
            fill_reg   <= '0;
            len_reg    <= '0;
            digits_reg <= '0;
            stop_reg   <= 1'b0;
            left_reg   <= '0;
            sum_reg    <= '0;
            kind_reg   <= KIND_RE;
        end else if (advance) begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            digits_reg <= digits_next;
            stop_reg   <= stop_next;
            left_reg   <= left_next;
            sum_reg    <= sum_next;
            kind_reg   <= kind_next;
        end
    end

    a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == BODY |-> left_reg != '0)
        else $error("body phase with no bytes left");

    a_emit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> phase_reg == HUNT && fill_reg == 2'd0)
        else $error("message end did not restart the hunt");

    a_ok_means_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.check_ok |->
            result.msg_kind == KIND_RE || result.computed_sum == result.received_sum)
        else $error("pass flag without matching checksum");

    a_length_digits: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == LENGTH |-> digits_reg < 2'(LEN_DIGITS))
        else $error("too many length characters");

endmodule

`default_nettype wire
